/* hw/rtl/rti_pkg.sv */
// Shared types and constants for the ray/triangle intersection block.
// Used by every module under hw/rtl; depends on nothing.
`default_nettype none
package rti_pkg;

   localparam int LIMB_W      = 32;  // slice width of the wide multipliers
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;
   localparam int EPS_W       = 16;
   localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;

   // item kinds carried in tuser bit 0
   localparam logic MODE_RAY = 1'b0;
   localparam logic MODE_TRI = 1'b1;

   typedef struct packed {
      logic empty;
      logic full;
   } rti_qstat_type;

   // control that travels alongside the divider lanes
   typedef struct packed {
      logic valid;
      logic hit;
      logic tneg;
      logic tovf;
   } rti_side_type;

endpackage
`default_nettype wire

/* hw/rtl/rti_wmul.sv */
// Two-stage signed multiplier for wide operands, split into 32-bit slices.
// Depends on rti_pkg (slice width).
`default_nettype none
module rti_wmul #(
   parameter int AW = 33,
   parameter int BW = 33
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [AW-1:0] a,
   input  logic signed [BW-1:0] b,
   output logic signed [AW+BW-1:0] p
);
   import rti_pkg::*;

   localparam int NA = (AW + LIMB_W - 1) / LIMB_W;
   localparam int NB = (BW + LIMB_W - 1) / LIMB_W;
   localparam int SW = (NA + NB) * LIMB_W + 2;
   localparam int PP = 2 * LIMB_W + 2;

   logic signed [NA*LIMB_W-1:0] a_ext;
   logic signed [NB*LIMB_W-1:0] b_ext;
   logic signed [LIMB_W:0]      a_limb [NA];
   logic signed [LIMB_W:0]      b_limb [NB];
   logic signed [PP-1:0]        pp_ff [NA][NB];
   logic signed [SW-1:0]        acc;
   logic signed [AW+BW-1:0]     p_ff;

   assign a_ext = (NA*LIMB_W)'(a);
   assign b_ext = (NB*LIMB_W)'(b);

   // lower slices are unsigned, the top slice carries the sign
   for (genvar i = 0; i < NA; i++) begin : g_alimb
      if (i == NA - 1) begin : g_top
         assign a_limb[i] = $signed({a_ext[(i+1)*LIMB_W-1], a_ext[i*LIMB_W +: LIMB_W]});
      end else begin : g_low
         assign a_limb[i] = $signed({1'b0, a_ext[i*LIMB_W +: LIMB_W]});
      end
   end
   for (genvar j = 0; j < NB; j++) begin : g_blimb
      if (j == NB - 1) begin : g_top
         assign b_limb[j] = $signed({b_ext[(j+1)*LIMB_W-1], b_ext[j*LIMB_W +: LIMB_W]});
      end else begin : g_low
         assign b_limb[j] = $signed({1'b0, b_ext[j*LIMB_W +: LIMB_W]});
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
               pp_ff[i][j] <= a_limb[i] * b_limb[j];
            end
         end
      end
   end

   always_comb begin
      acc = '0;
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            acc = acc + (SW'(pp_ff[i][j]) << ((i + j) * LIMB_W));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= acc[AW+BW-1:0];
      end
   end

   assign p = p_ff;

endmodule
`default_nettype wire

/* hw/rtl/rti_div.sv */
// Pipelined restoring divider, three numerator lanes over one shared divisor,
// one quotient bit per stage. Depends on rti_pkg (sideband type).
`default_nettype none
module rti_div #(
   parameter int NW = 118,
   parameter int QB = 31
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic [2:0][NW-1:0]         num,
   input  logic [NW-1:0]              den,
   input  rti_pkg::rti_side_type      side_in,
   output logic [2:0][QB-1:0]         quo,
   output rti_pkg::rti_side_type      side_out
);
   import rti_pkg::*;

   localparam int RW = NW + QB;

   logic [2:0][RW-1:0] rem_ff  [QB];
   logic [NW-1:0]      den_ff  [QB];
   logic [2:0][QB-1:0] quo_ff  [QB];
   rti_side_type       side_ff [QB];

   logic [2:0][RW-1:0] rem_src  [QB];
   logic [NW-1:0]      den_src  [QB];
   logic [2:0][QB-1:0] quo_src  [QB];
   rti_side_type       side_src [QB];

   for (genvar s = 0; s < QB; s++) begin : g_stage
      localparam int K = QB - 1 - s;
      logic [RW-1:0] dsh;

      if (s == 0) begin : g_head
         for (genvar l = 0; l < 3; l++) begin : g_lane
            assign rem_src[s][l] = RW'(num[l]);
         end
         assign den_src[s]  = den;
         assign quo_src[s]  = '0;
         assign side_src[s] = side_in;
      end else begin : g_body
         assign rem_src[s]  = rem_ff[s-1];
         assign den_src[s]  = den_ff[s-1];
         assign quo_src[s]  = quo_ff[s-1];
         assign side_src[s] = side_ff[s-1];
      end

      assign dsh = RW'(den_src[s]) << K;

      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff[s] <= '0;
         end else if (en) begin
            side_ff[s] <= side_src[s];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            den_ff[s] <= den_src[s];
            for (int l = 0; l < 3; l++) begin
               if (rem_src[s][l] >= dsh) begin
                  rem_ff[s][l] <= rem_src[s][l] - dsh;
                  quo_ff[s][l] <= quo_src[s][l] | (QB'(1) << K);
               end else begin
                  rem_ff[s][l] <= rem_src[s][l];
                  quo_ff[s][l] <= quo_src[s][l];
               end
            end
         end
      end
   end

   assign quo      = quo_ff[QB-1];
   assign side_out = side_ff[QB-1];

endmodule
`default_nettype wire

/* hw/rtl/rti_queue.sv */
// Short register queue between the front and back parts.
// Depends on rti_pkg (depth, status type).
`default_nettype none
module rti_queue #(
   parameter int DW = 327
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  logic [DW-1:0]          push_data,
   input  logic                   pop,
   output logic [DW-1:0]          pop_data,
   output rti_pkg::rti_qstat_type qstat
);
   import rti_pkg::*;

   logic [DW-1:0]       mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_AW:0]   count_ff;

   assign qstat.empty = (count_ff == '0);
   assign qstat.full  = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign pop_data    = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !qstat.full) else $error("queue push while full");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !qstat.empty) else $error("queue pop while empty");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QUEUE_AW+1)'(QUEUE_DEPTH)) else $error("queue count overrun");

endmodule
`default_nettype wire

/* hw/rtl/rti_front.sv */
// Front part: takes request words, sorts ray loads from triangles and forms
// the triangle edges. Depends on rti_pkg (item kinds, queue status).
`default_nettype none
module rti_front #(
   parameter  int W     = 32,
   localparam int IN_W  = ((10 * W - 1 + 7) / 8) * 8,
   localparam int ENT_W = 10 * W + 7
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [IN_W-1:0]        req_tdata,
   input  logic [1:0]             req_tuser,
   input  rti_pkg::rti_qstat_type qstat,
   output logic                   push,
   output logic [ENT_W-1:0]       push_data
);
   import rti_pkg::*;

   localparam int EW = W + 1;

   logic                 f_valid_ff;
   logic [ENT_W-1:0]     f_data_ff;
   logic [ENT_W-1:0]     ent_in;
   logic                 accept;
   logic                 mode, dsided;
   logic [W-2:0]         far;
   logic signed [W-1:0]  first  [3];
   logic signed [W-1:0]  second [3];
   logic signed [W-1:0]  third  [3];
   logic signed [EW-1:0] eb [3];
   logic signed [EW-1:0] ec [3];

   assign mode   = req_tuser[0];
   assign dsided = req_tuser[1];
   assign far    = req_tdata[9*W +: W-1];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         first[i]  = $signed(req_tdata[i*W +: W]);
         second[i] = $signed(req_tdata[(3+i)*W +: W]);
         third[i]  = $signed(req_tdata[(6+i)*W +: W]);
         // ray loads keep the direction as is
         if (mode == MODE_TRI) begin
            eb[i] = EW'(second[i]) - EW'(first[i]);
         end else begin
            eb[i] = EW'(second[i]);
         end
         ec[i] = EW'(third[i]) - EW'(first[i]);
      end
      ent_in = {mode, dsided, far, first[0], first[1], first[2],
                eb[0], eb[1], eb[2], ec[0], ec[1], ec[2]};
   end

   assign push       = f_valid_ff && !qstat.full;
   assign req_tready = !f_valid_ff || !qstat.full;
   assign accept     = req_tvalid && req_tready;
   assign push_data  = f_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (accept) begin
         f_valid_ff <= 1'b1;
      end else if (push) begin
         f_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         f_data_ff <= ent_in;
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/rti_back.sv */
// Back part: holds the ray, runs the cross/dot products, bound tests and the
// divider pipeline, and drives the response. Depends on rti_pkg, rti_wmul, rti_div.
`default_nettype none
module rti_back #(
   parameter  int W     = 32,
   parameter  int F     = 16,
   localparam int ENT_W = 10 * W + 7,
   localparam int OUT_W = ((2 * F + 2 + W + 7) / 8) * 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [rti_pkg::EPS_W-1:0]  epsilon,
   input  rti_pkg::rti_qstat_type     qstat,
   output logic                       pop,
   input  logic [ENT_W-1:0]           pop_data,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [OUT_W-1:0]           rsp_tdata,
   output logic                       rsp_tuser
);
   import rti_pkg::*;

   localparam int EW  = W + 1;
   localparam int CXW = 2 * W + 2;
   localparam int PW  = 2 * W + 3;
   localparam int DTW = 3 * W + 4;
   localparam int DW  = 3 * W + 6;
   localparam int CW  = DW + F + 34;
   localparam int NW  = DW + F;
   localparam int QB  = W - 1;

   typedef struct packed {
      logic              valid;
      logic              ds;
      logic [W-2:0]      far;
      logic [2:0][EW-1:0] dir;
      logic [2:0][EW-1:0] e1;
      logic [2:0][EW-1:0] e2;
      logic [2:0][EW-1:0] tv;
   } geo_type;

   typedef struct packed {
      logic              valid;
      logic              ds;
      logic [W-2:0]      far;
      logic [2:0][EW-1:0] dir;
      logic [2:0][EW-1:0] e1;
      logic [2:0][EW-1:0] e2;
      logic [2:0][EW-1:0] tv;
      logic [2:0][PW-1:0] p;
      logic [2:0][PW-1:0] q;
   } crs_type;

   typedef struct packed {
      logic         valid;
      logic         ds;
      logic [W-2:0] far;
   } ctl_type;

   typedef struct packed {
      logic         valid;
      logic         ds;
      logic [W-2:0] far;
      logic [DW-1:0] d;
      logic [DW-1:0] u;
      logic [DW-1:0] v;
      logic [DW-1:0] t;
   } dot_type;

   typedef struct packed {
      logic          valid;
      logic          ds;
      logic [W-2:0]  far;
      logic          dz;
      logic          dge;
      logic          tneg;
      logic [DW-1:0] d;
      logic [DW-1:0] u;
      logic [DW-1:0] v;
      logic [DW-1:0] t;
      logic [DW-1:0] tabs;
   } nrm_type;

   logic adv;

   // queue head
   logic                 q_mode, q_ds;
   logic [W-2:0]         q_far;
   logic signed [W-1:0]  q_v0 [3];
   logic signed [EW-1:0] q_b [3];
   logic signed [EW-1:0] q_c [3];

   // stored ray
   logic signed [W-1:0] org_ff [3];
   logic signed [W-1:0] dir_ff [3];
   logic [W-2:0]        far_ff;

   geo_type a_ff, b_ff, c_ff, a_in;
   crs_type d_ff;
   ctl_type e_ff, f_ff;
   dot_type g_ff;
   nrm_type h_ff, i_ff, j_ff, h_in;

   logic signed [CXW-1:0] px1 [3], px2 [3], qx1 [3], qx2 [3];
   logic signed [DTW-1:0] dd [3], du [3], dv [3], dt [3];
   logic signed [EPS_W+DW:0] ed_p;
   logic signed [W+DW-1:0]   fd_p;

   logic signed [DW-1:0] gd, gu, gv, gt, es, nes;
   logic                 flip, gneg, tnegr;

   logic signed [CW-1:0] ku, kv, kd, kt, ked, kfd, kuv, klhs, ktf, ktabs;
   logic                 dbl_ok, sgl_ok, k_hit, k_tovf;

   logic [2:0][NW-1:0] k_num_ff;
   logic [NW-1:0]      k_den_ff;
   rti_side_type       k_side_ff, div_side;
   logic [2:0][QB-1:0] div_quo;

   logic           out_valid_ff, out_hit_ff;
   logic [F:0]     out_u_ff, out_v_ff;
   logic [W-1:0]   out_t_ff;
   logic [W-1:0]   t_mag, t_res;

   assign adv = !out_valid_ff || rsp_tready;
   assign pop = adv && !qstat.empty;

   always_comb begin
      {q_mode, q_ds, q_far, q_v0[0], q_v0[1], q_v0[2],
       q_b[0], q_b[1], q_b[2], q_c[0], q_c[1], q_c[2]} = pop_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            org_ff[i] <= '0;
            dir_ff[i] <= '0;
         end
         far_ff <= '0;
      end else if (pop && q_mode == MODE_RAY) begin
         for (int i = 0; i < 3; i++) begin
            org_ff[i] <= q_v0[i];
            dir_ff[i] <= q_b[i][W-1:0];
         end
         far_ff <= q_far;
      end
   end

   // stage a: triangle against the current ray
   always_comb begin
      a_in.valid = pop && q_mode == MODE_TRI;
      a_in.ds    = q_ds;
      a_in.far   = far_ff;
      for (int i = 0; i < 3; i++) begin
         a_in.dir[i] = EW'(dir_ff[i]);
         a_in.e1[i]  = q_b[i];
         a_in.e2[i]  = q_c[i];
         a_in.tv[i]  = EW'(org_ff[i]) - EW'(q_v0[i]);
      end
   end

   // cross products p = dir x e2, q = tv x e1
   for (genvar c = 0; c < 3; c++) begin : g_cross
      localparam int C1 = (c + 1) % 3;
      localparam int C2 = (c + 2) % 3;
      rti_wmul #(.AW(EW), .BW(EW)) u_px1 (.clock, .en(adv),
         .a($signed(a_ff.dir[C1])), .b($signed(a_ff.e2[C2])), .p(px1[c]));
      rti_wmul #(.AW(EW), .BW(EW)) u_px2 (.clock, .en(adv),
         .a($signed(a_ff.dir[C2])), .b($signed(a_ff.e2[C1])), .p(px2[c]));
      rti_wmul #(.AW(EW), .BW(EW)) u_qx1 (.clock, .en(adv),
         .a($signed(a_ff.tv[C1])), .b($signed(a_ff.e1[C2])), .p(qx1[c]));
      rti_wmul #(.AW(EW), .BW(EW)) u_qx2 (.clock, .en(adv),
         .a($signed(a_ff.tv[C2])), .b($signed(a_ff.e1[C1])), .p(qx2[c]));
   end

   // dot products D = e1.p, U = tv.p, V = dir.q, T = e2.q
   for (genvar c = 0; c < 3; c++) begin : g_dot
      rti_wmul #(.AW(EW), .BW(PW)) u_dd (.clock, .en(adv),
         .a($signed(d_ff.e1[c])), .b($signed(d_ff.p[c])), .p(dd[c]));
      rti_wmul #(.AW(EW), .BW(PW)) u_du (.clock, .en(adv),
         .a($signed(d_ff.tv[c])), .b($signed(d_ff.p[c])), .p(du[c]));
      rti_wmul #(.AW(EW), .BW(PW)) u_dv (.clock, .en(adv),
         .a($signed(d_ff.dir[c])), .b($signed(d_ff.q[c])), .p(dv[c]));
      rti_wmul #(.AW(EW), .BW(PW)) u_dt (.clock, .en(adv),
         .a($signed(d_ff.e2[c])), .b($signed(d_ff.q[c])), .p(dt[c]));
   end

   // stage h: threshold on D, sign normalization, |T|
   assign gd   = $signed(g_ff.d);
   assign gu   = $signed(g_ff.u);
   assign gv   = $signed(g_ff.v);
   assign gt   = $signed(g_ff.t);
   assign es   = $signed(DW'(epsilon) << (2 * F));
   assign nes  = -es;
   assign gneg = gd < 0;
   assign flip = g_ff.ds && gneg;
   assign tnegr = gt < 0;

   always_comb begin
      h_in.valid = g_ff.valid;
      h_in.ds    = g_ff.ds;
      h_in.far   = g_ff.far;
      h_in.dz    = (gd == '0);
      h_in.dge   = g_ff.ds ? (gd >= es || gd <= nes) : (gd >= es);
      h_in.tneg  = tnegr ^ flip;
      h_in.d     = flip ? -gd : gd;
      h_in.u     = flip ? -gu : gu;
      h_in.v     = flip ? -gv : gv;
      h_in.t     = flip ? -gt : gt;
      h_in.tabs  = tnegr ? -gt : gt;
   end

   rti_wmul #(.AW(EPS_W+1), .BW(DW)) u_ed (.clock, .en(adv),
      .a($signed({1'b0, epsilon})), .b($signed(h_ff.d)), .p(ed_p));
   rti_wmul #(.AW(W), .BW(DW)) u_fd (.clock, .en(adv),
      .a($signed({1'b0, h_ff.far})), .b($signed(h_ff.d)), .p(fd_p));

   // stage k: bound tests
   always_comb begin
      ku    = CW'($signed(j_ff.u));
      kv    = CW'($signed(j_ff.v));
      kd    = CW'($signed(j_ff.d));
      kt    = CW'($signed(j_ff.t));
      ktabs = CW'($signed(j_ff.tabs));
      ked   = CW'(ed_p);
      kfd   = CW'(fd_p);
      kuv   = ku + kv;
      klhs  = (kuv << F) + ked;
      ktf   = kt << F;
      dbl_ok = ku >= 0 && ku <= kd && kv >= 0 && klhs < (kd << F)
               && ktf > ked && ktf < kfd;
      sgl_ok = ku >= 0 && ku <= kd && kv >= 0 && kuv <= kd;
      k_hit  = !j_ff.dz && j_ff.dge && (j_ff.ds ? dbl_ok : sgl_ok);
      k_tovf = ktabs >= (kd << (W - 1 - F));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff      <= '0;
         b_ff      <= '0;
         c_ff      <= '0;
         d_ff      <= '0;
         e_ff      <= '0;
         f_ff      <= '0;
         g_ff      <= '0;
         h_ff      <= '0;
         i_ff      <= '0;
         j_ff      <= '0;
         k_side_ff <= '0;
      end else if (adv) begin
         a_ff <= a_in;
         b_ff <= a_ff;
         c_ff <= b_ff;
         d_ff.valid <= c_ff.valid;
         d_ff.ds    <= c_ff.ds;
         d_ff.far   <= c_ff.far;
         d_ff.dir   <= c_ff.dir;
         d_ff.e1    <= c_ff.e1;
         d_ff.e2    <= c_ff.e2;
         d_ff.tv    <= c_ff.tv;
         for (int i = 0; i < 3; i++) begin
            d_ff.p[i] <= PW'(px1[i]) - PW'(px2[i]);
            d_ff.q[i] <= PW'(qx1[i]) - PW'(qx2[i]);
         end
         e_ff <= '{valid: d_ff.valid, ds: d_ff.ds, far: d_ff.far};
         f_ff <= e_ff;
         g_ff.valid <= f_ff.valid;
         g_ff.ds    <= f_ff.ds;
         g_ff.far   <= f_ff.far;
         g_ff.d     <= DW'(dd[0]) + DW'(dd[1]) + DW'(dd[2]);
         g_ff.u     <= DW'(du[0]) + DW'(du[1]) + DW'(du[2]);
         g_ff.v     <= DW'(dv[0]) + DW'(dv[1]) + DW'(dv[2]);
         g_ff.t     <= DW'(dt[0]) + DW'(dt[1]) + DW'(dt[2]);
         h_ff <= h_in;
         i_ff <= h_ff;
         j_ff <= i_ff;
         k_side_ff <= '{valid: j_ff.valid, hit: k_hit, tneg: j_ff.tneg, tovf: k_tovf};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         k_num_ff[0] <= NW'(j_ff.u) << F;
         k_num_ff[1] <= NW'(j_ff.v) << F;
         k_num_ff[2] <= NW'(j_ff.tabs) << F;
         k_den_ff    <= NW'(j_ff.d);
      end
   end

   rti_div #(.NW(NW), .QB(QB)) u_div (
      .clock, .reset, .en(adv),
      .num(k_num_ff), .den(k_den_ff), .side_in(k_side_ff),
      .quo(div_quo), .side_out(div_side)
   );

   assign t_mag = W'(div_quo[2]);
   always_comb begin
      if (div_side.tovf) begin
         t_res = div_side.tneg ? {1'b1, (W-1)'(0)} : {1'b0, {(W-1){1'b1}}};
      end else begin
         t_res = div_side.tneg ? -t_mag : t_mag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= div_side.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_hit_ff <= div_side.hit;
         out_u_ff   <= div_side.hit ? div_quo[0][F:0] : '0;
         out_v_ff   <= div_side.hit ? div_quo[1][F:0] : '0;
         out_t_ff   <= div_side.hit ? t_res : '0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_hit_ff;
   assign rsp_tdata  = OUT_W'({out_t_ff, out_v_ff, out_u_ff});

endmodule
`default_nettype wire

/* hw/rtl/ray_triangle_intersect_top.sv */
// Top level of the ray/triangle intersection block: epsilon register, front,
// queue and back. Depends on rti_pkg, rti_front, rti_queue, rti_back.
//
//  port group | dir | word contents (low bit first)
//  req_*      | in  | tdata: first xyz, second xyz, third xyz, far_limit; tuser: mode, double_sided
//  rsp_*      | out | tdata: u_out, v_out, t_out; tuser: hit
//  csr_*      | in  | epsilon write, no read-back
//
// One word per cycle sustained on both sides while rsp_tready stays high. A triangle
// result passes the two-stage multiply rows and then the one-bit-per-stage divider
// (COORD_WIDTH - 1 stages) before it is presented.
// Ray loads give no response word and update the ray in order with triangles.
// Reset is synchronous; epsilon resets to one LSB, the ray to zero.
// rsp_tready low while a response word is held freezes the back part; the front keeps filling its 4-entry queue.
`default_nettype none
module ray_triangle_intersect_top #(
   parameter  int COORD_WIDTH   = 32,
   parameter  int FRACTION_BITS = 16,
   localparam int IN_W  = ((10 * COORD_WIDTH - 1 + 7) / 8) * 8,
   localparam int OUT_W = ((2 * FRACTION_BITS + 2 + COORD_WIDTH + 7) / 8) * 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [IN_W-1:0]           req_tdata,   // first_x/y/z, second_x/y/z, third_x/y/z, far_limit
   input  logic [1:0]                req_tuser,   // mode, double_sided
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [OUT_W-1:0]          rsp_tdata,   // u_out, v_out, t_out
   output logic                      rsp_tuser,   // hit
   input  logic                      csr_wr_en,
   input  logic [rti_pkg::EPS_W-1:0] csr_wr_data
);
   import rti_pkg::*;

   localparam int ENT_W = 10 * COORD_WIDTH + 7;

   logic [EPS_W-1:0] epsilon_ff;
   logic             push, pop;
   logic [ENT_W-1:0] push_data, pop_data;
   rti_qstat_type    qstat;

   always_ff @(posedge clock) begin
      if (reset) begin
         epsilon_ff <= EPS_RESET;
      end else if (csr_wr_en) begin
         epsilon_ff <= csr_wr_data;
      end
   end

   rti_front #(.W(COORD_WIDTH)) u_front (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .qstat, .push, .push_data
   );

   rti_queue #(.DW(ENT_W)) u_queue (
      .clock, .reset,
      .push, .push_data, .pop, .pop_data, .qstat
   );

   rti_back #(.W(COORD_WIDTH), .F(FRACTION_BITS)) u_back (
      .clock, .reset, .epsilon(epsilon_ff),
      .qstat, .pop, .pop_data,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
   );

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0) else $error("miss with nonzero fields");
   a_u_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[FRACTION_BITS:0] <= (FRACTION_BITS+1)'(1) << FRACTION_BITS)
      else $error("u above one");

endmodule
`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for ray_triangle_intersect_top: ray loads and triangle tests
// are streamed in, and every response word is checked against a fixed-point intersection
// predictor. Depends on rti_pkg and the block's RTL.
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rti_pkg::*;

   localparam int IN_W  = 320;
   localparam int OUT_W = 72;
   localparam int ONE   = 65536;

   typedef logic signed [255:0] wide_type;

   typedef struct packed {
      logic             mode;
      logic             dside;
      logic [30:0]      far;
      logic [2:0][31:0] p0;   // index 0 = x
      logic [2:0][31:0] p1;
      logic [2:0][31:0] p2;
   } geo_word_type;

   typedef struct packed {
      logic        hit;
      logic [16:0] u;
      logic [16:0] v;
      logic [31:0] t;
   } isect_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [IN_W-1:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [OUT_W-1:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_wr_en = 1'b0;
   logic [EPS_W-1:0] csr_wr_data = '0;

   ray_triangle_intersect_top DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   geo_word_type pending_words[$];
   isect_type    expected_isects[$];
   geo_word_type cur_word;
   int        send_idle_pct = 0;
   int        recv_stall_pct = 0;
   int        mismatches = 0;

   // predictor state
   logic [EPS_W-1:0] eps_cur = EPS_RESET;
   logic [2:0][31:0] ray_org = '0;
   logic [2:0][31:0] ray_dir = '0;
   logic [30:0]      ray_far = '0;

   function automatic isect_type intersect_predict(geo_word_type w);
      wide_type v0[3], e1[3], e2[3], dr[3], tv[3], p[3], q[3];
      wide_type dd, uu, vv, tt, ew, es, ed, tf, fw, uq, vq, tm;
      isect_type r;
      logic h;
      for (int i = 0; i < 3; i++) begin
         v0[i] = $signed(w.p0[i]);
         e1[i] = wide_type'($signed(w.p1[i])) - v0[i];
         e2[i] = wide_type'($signed(w.p2[i])) - v0[i];
         dr[i] = $signed(ray_dir[i]);
         tv[i] = wide_type'($signed(ray_org[i])) - v0[i];
      end
      p[0] = dr[1] * e2[2] - dr[2] * e2[1];
      p[1] = dr[2] * e2[0] - dr[0] * e2[2];
      p[2] = dr[0] * e2[1] - dr[1] * e2[0];
      q[0] = tv[1] * e1[2] - tv[2] * e1[1];
      q[1] = tv[2] * e1[0] - tv[0] * e1[2];
      q[2] = tv[0] * e1[1] - tv[1] * e1[0];
      dd = e1[0] * p[0] + e1[1] * p[1] + e1[2] * p[2];
      uu = tv[0] * p[0] + tv[1] * p[1] + tv[2] * p[2];
      vv = dr[0] * q[0] + dr[1] * q[1] + dr[2] * q[2];
      tt = e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2];
      ew = '0;
      ew[15:0] = eps_cur;
      es = ew <<< 32;
      fw = '0;
      fw[30:0] = ray_far;
      h = 1'b0;
      if (dd == 0) begin
         h = 1'b0;
      end else if (w.dside) begin
         if ((dd < 0 ? -dd : dd) >= es) begin
            if (dd < 0) begin
               dd = -dd; uu = -uu; vv = -vv; tt = -tt;
            end
            ed = ew * dd;
            tf = tt <<< 16;
            h = uu >= 0 && uu <= dd && vv >= 0
                && (((uu + vv) <<< 16) + ed) < (dd <<< 16)
                && tf > ed && tf < fw * dd;
         end
      end else begin
         h = dd >= es && uu >= 0 && uu <= dd && vv >= 0 && uu + vv <= dd;
      end
      r = '0;
      if (h) begin
         uq = (uu <<< 16) / dd;
         vq = (vv <<< 16) / dd;
         tm = ((tt < 0 ? -tt : tt) <<< 16) / dd;
         r.hit = 1'b1;
         r.u = (uq > ONE) ? 17'(ONE) : uq[16:0];
         r.v = (vq > ONE) ? 17'(ONE) : vq[16:0];
         if (tt < 0)
            r.t = (tm >= 256'sh8000_0000) ? 32'h8000_0000 : 32'(0 - tm[31:0]);
         else
            r.t = (tm > 256'sh7fff_ffff) ? 32'h7fff_ffff : tm[31:0];
      end
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (cur_word.mode == MODE_RAY) begin
               ray_org = cur_word.p0;
               ray_dir = cur_word.p1;
               ray_far = cur_word.far;
            end else begin
               expected_isects.push_back(intersect_predict(cur_word));
            end
         end
         if (!req_tvalid || req_tready) begin
            if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               cur_word = pending_words.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {1'b0, cur_word.far, cur_word.p2, cur_word.p1, cur_word.p0};
               req_tuser <= {cur_word.dside, cur_word.mode};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      isect_type got, want;
      rsp_tready <= !reset && ($urandom_range(0, 99) >= recv_stall_pct);
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.hit = rsp_tuser;
         got.u = rsp_tdata[16:0];
         got.v = rsp_tdata[33:17];
         got.t = rsp_tdata[65:34];
         if (expected_isects.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected response word hit=%0d u=%0d v=%0d t=%0d",
                        got.hit, got.u, got.v, $signed(got.t));
         end else begin
            want = expected_isects.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: exp hit=%0d u=%0d v=%0d t=%0d, got hit=%0d u=%0d v=%0d t=%0d",
                           want.hit, want.u, want.v, $signed(want.t),
                           got.hit, got.u, got.v, $signed(got.t));
            end
         end
      end
   end

   function automatic geo_word_type mk(logic mode, int ds, int far,
                                       int ax, int ay, int az, int bx, int by, int bz,
                                       int cx, int cy, int cz);
      geo_word_type w;
      w.mode = mode; w.dside = ds[0]; w.far = far[30:0];
      w.p0 = {az, ay, ax};
      w.p1 = {bz, by, bx};
      w.p2 = {cz, cy, cx};
      return w;
   endfunction

   function automatic int rnd_mag(int bits);
      int x;
      x = $urandom_range(0, (1 << bits) - 1);
      return $urandom_range(0, 1) ? -x : x;
   endfunction

   function automatic geo_word_type rnd_noise();
      logic [351:0] raw;
      geo_word_type w;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom, $urandom};
      w = raw[$bits(geo_word_type)-1:0];
      return w;
   endfunction

   task automatic push_random(int count);
      int o[3], d[3], c[3], k;
      geo_word_type w;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < 12) begin
            w = rnd_noise();
         end else if (n == 0 || $urandom_range(0, 5) == 0) begin
            for (int i = 0; i < 3; i++) begin
               o[i] = rnd_mag(22);
               d[i] = rnd_mag(17);
            end
            w = mk(MODE_RAY, $urandom_range(0, 1),
                   $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 25),
                   o[0], o[1], o[2], d[0], d[1], d[2], $urandom, $urandom, $urandom);
         end else begin
            // triangle around a point on the current ray
            k = $urandom_range(0, 3) == 0 ? -$urandom_range(1, 4) : $urandom_range(1, 16);
            for (int i = 0; i < 3; i++) c[i] = o[i] + d[i] * k;
            w = mk(MODE_TRI, $urandom_range(0, 1), $urandom,
                   c[0] + rnd_mag(20), c[1] + rnd_mag(20), c[2] + rnd_mag(20),
                   c[0] + rnd_mag(20), c[1] + rnd_mag(20), c[2] + rnd_mag(20),
                   c[0] + rnd_mag(20), c[1] + rnd_mag(20), c[2] + rnd_mag(20));
         end
         pending_words.push_back(w);
      end
   endtask

   task automatic drain();
      while (pending_words.size() > 0 || req_tvalid || expected_isects.size() > 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_eps(logic [EPS_W-1:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      eps_cur = val;
   endtask

   initial begin
      logic [EPS_W-1:0] eps_list[5];
      eps_list = '{16'd1, 16'd0, 16'hffff, 16'd0, 16'd300};
      eps_list[3] = EPS_W'($urandom);
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: triangle with no ray loaded yet, then an axis-aligned ray
      pending_words.push_back(mk(MODE_TRI, 1, 0, 0, 0, 5*ONE, ONE, 0, 5*ONE, 0, ONE, 5*ONE));
      pending_words.push_back(mk(MODE_RAY, 0, 100*ONE, 0, 0, 0, 0, 0, ONE, -1, -1, -1));
      // back-facing winding, then front-facing, both culling modes
      pending_words.push_back(mk(MODE_TRI, 0, 0, -ONE, -ONE, 5*ONE, ONE, -ONE, 5*ONE,
                                 -ONE, ONE, 5*ONE));
      pending_words.push_back(mk(MODE_TRI, 1, 0, -ONE, -ONE, 5*ONE, ONE, -ONE, 5*ONE,
                                 -ONE, ONE, 5*ONE));
      pending_words.push_back(mk(MODE_TRI, 0, 0, -ONE, -ONE, 5*ONE, -ONE, ONE, 5*ONE,
                                 ONE, -ONE, 5*ONE));
      pending_words.push_back(mk(MODE_TRI, 1, 0, -ONE, -ONE, 5*ONE, -ONE, ONE, 5*ONE,
                                 ONE, -ONE, 5*ONE));
      // plane parallel to the ray
      pending_words.push_back(mk(MODE_TRI, 1, 0, 0, -ONE, 0, 0, ONE, 0, 0, 0, ONE));
      // behind the origin: negative t when culling, miss otherwise
      pending_words.push_back(mk(MODE_TRI, 0, 0, -ONE, -ONE, -5*ONE, -ONE, ONE, -5*ONE,
                                 ONE, -ONE, -5*ONE));
      pending_words.push_back(mk(MODE_TRI, 1, 0, -ONE, -ONE, -5*ONE, -ONE, ONE, -5*ONE,
                                 ONE, -ONE, -5*ONE));
      // past the far limit
      pending_words.push_back(mk(MODE_TRI, 1, 0, -ONE, -ONE, 200*ONE, -ONE, ONE, 200*ONE,
                                 ONE, -ONE, 200*ONE));
      pending_words.push_back(mk(MODE_TRI, 0, 0, -ONE, -ONE, 200*ONE, -ONE, ONE, 200*ONE,
                                 ONE, -ONE, 200*ONE));
      // ray through a vertex (u or v at one)
      pending_words.push_back(mk(MODE_TRI, 0, 0, -ONE, 0, 5*ONE, 0, 0, 5*ONE, ONE, ONE, 5*ONE));
      // tiny direction: t saturates
      pending_words.push_back(mk(MODE_RAY, 1, 32'h7fff_ffff, 0, 0, 0, 0, 0, 1, 0, 0, 0));
      pending_words.push_back(mk(MODE_TRI, 0, 0, -ONE, -ONE, 30000*ONE, -ONE, ONE, 30000*ONE,
                                 ONE, -ONE, 30000*ONE));
      pending_words.push_back(mk(MODE_TRI, 0, 0, -ONE, -ONE, -30000*ONE, -ONE, ONE,
                                 -30000*ONE, ONE, -ONE, -30000*ONE));
      // extreme coordinates
      pending_words.push_back(mk(MODE_RAY, 1, -1, 32'h8000_0000, 32'h7fff_ffff, -1,
                                 32'h7fff_ffff, 32'h8000_0000, 1, -1, -1, -1));
      pending_words.push_back(mk(MODE_TRI, 1, -1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                 32'h7fff_ffff, 32'h8000_0000, 0));
      pending_words.push_back(mk(MODE_TRI, 0, 0, 32'h8000_0000, 0, 32'h7fff_ffff,
                                 32'h7fff_ffff, 32'h8000_0000, -1, 0, 32'h7fff_ffff, 1));
      drain();

      for (int ph = 0; ph < 5; ph++) begin
         write_eps(eps_list[ph]);
         if (ph == 1) begin
            // degenerate triangle, determinant exactly zero with epsilon zero
            pending_words.push_back(mk(MODE_RAY, 0, ONE, 0, 0, 0, 0, 0, ONE, 0, 0, 0));
            pending_words.push_back(mk(MODE_TRI, 1, 0, 0, 0, ONE, 0, 0, ONE, 0, 0, ONE));
            pending_words.push_back(mk(MODE_TRI, 0, 0, 0, 0, ONE, 0, 0, ONE, 0, 0, ONE));
         end
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
            default: begin send_idle_pct = 35; recv_stall_pct = 35; end
         endcase
         push_random(65);
         drain();   // sender holds off until every response is back
         push_random(65);
         drain();
      end

      if (mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #400000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
`default_nettype wire
